[rtl/core/bwa_pkg.sv]
// ----------------------------------------------------------------------------
// bwa_pkg
// Shared sizes, digit constants and the control struct of the decimal
// wheel accumulator.
// ----------------------------------------------------------------------------
package bwa_pkg;

  // accumulator geometry
  localparam int NUM_DIGITS  = 24;
  localparam int LOW_DIGITS  = 19;
  localparam int DIGIT_W     = 4;
  localparam int OPND_W      = 64;
  localparam int CONV_DIGITS = 20;  // decimal digits of a 64-bit operand
  localparam int TALLY_W     = 5;
  localparam int TALLY_MAX   = 31;

  // step counter covers the conversion and both ring passes
  localparam int CNT_STEPS   = (OPND_W > NUM_DIGITS) ? OPND_W : NUM_DIGITS;
  localparam int CNT_W       = $clog2(CNT_STEPS);

  localparam logic [DIGIT_W-1:0] DEC_BASE  = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] DABBLE_TH = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] DABBLE_AD = DIGIT_W'(3);

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_ADD  = 1'b1;

  typedef logic [DIGIT_W-1:0] digit_t;

  // sequencer strobes to the datapath units
  typedef struct packed {
    logic start;    // new word taken
    logic conv_en;  // one double-dabble step
    logic add_en;   // one digit through the ring adder
    logic read_en;  // one digit out to the binary readout
    logic read_take;// digit belongs to the low part
    logic is_add;   // add request, else load
  } ctrl_t;

endpackage

[rtl/core/bwa_b2d.sv]
// ----------------------------------------------------------------------------
// bwa_b2d
// Bit-serial binary to BCD converter (double dabble, one bit per cycle),
// then shifts its digits out lowest first, one per cycle.
// ----------------------------------------------------------------------------
module bwa_b2d (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bwa_pkg::ctrl_t              ctrl_i,
  input  logic [bwa_pkg::OPND_W-1:0]  operand_i,
  output bwa_pkg::digit_t             digit_o
);

  logic [bwa_pkg::OPND_W-1:0] bin_q, bin_d;
  bwa_pkg::digit_t            bcd_q [bwa_pkg::CONV_DIGITS];
  bwa_pkg::digit_t            bcd_d [bwa_pkg::CONV_DIGITS];
  bwa_pkg::digit_t            adj   [bwa_pkg::CONV_DIGITS];

  // add-3 correction on every digit ahead of the shift
  always_comb begin
    for (int i = 0; i < bwa_pkg::CONV_DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= bwa_pkg::DABBLE_TH) ? bcd_q[i] + bwa_pkg::DABBLE_AD
                                                : bcd_q[i];
    end
  end

  // next value of the binary and digit shift registers
  always_comb begin
    bin_d = bin_q;
    for (int i = 0; i < bwa_pkg::CONV_DIGITS; i++) begin
      bcd_d[i] = bcd_q[i];
    end
    if (ctrl_i.start) begin
      bin_d = operand_i;
      for (int i = 0; i < bwa_pkg::CONV_DIGITS; i++) begin
        bcd_d[i] = '0;
      end
    end else if (ctrl_i.conv_en) begin
      bin_d    = {bin_q[bwa_pkg::OPND_W-2:0], 1'b0};
      bcd_d[0] = {adj[0][bwa_pkg::DIGIT_W-2:0], bin_q[bwa_pkg::OPND_W-1]};
      for (int i = 1; i < bwa_pkg::CONV_DIGITS; i++) begin
        bcd_d[i] = {adj[i][bwa_pkg::DIGIT_W-2:0], adj[i-1][bwa_pkg::DIGIT_W-1]};
      end
    end else if (ctrl_i.add_en) begin
      // digit shift-out, zeros fill from the top
      for (int i = 0; i < bwa_pkg::CONV_DIGITS - 1; i++) begin
        bcd_d[i] = bcd_q[i+1];
      end
      bcd_d[bwa_pkg::CONV_DIGITS-1] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
      for (int i = 0; i < bwa_pkg::CONV_DIGITS; i++) begin
        bcd_q[i] <= '0;
      end
    end else begin
      bin_q <= bin_d;
      for (int i = 0; i < bwa_pkg::CONV_DIGITS; i++) begin
        bcd_q[i] <= bcd_d[i];
      end
    end
  end

  assign digit_o = bcd_q[0];

endmodule

[rtl/core/bwa_ring.sv]
// ----------------------------------------------------------------------------
// bwa_ring
// Accumulator digit ring with a one-digit BCD adder. Rotates right while
// loading or adding, rotates left to feed the readout top digit first.
// ----------------------------------------------------------------------------
module bwa_ring (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bwa_pkg::ctrl_t               ctrl_i,
  input  bwa_pkg::digit_t              opnd_digit_i,
  output bwa_pkg::digit_t              top_digit_o,
  output logic [bwa_pkg::TALLY_W-1:0]  tally_o,
  output logic                         zero_o
);

  bwa_pkg::digit_t             ring_q [bwa_pkg::NUM_DIGITS];
  logic                        carry_q, carry_d;
  logic [bwa_pkg::TALLY_W-1:0] tally_q, tally_d;
  logic                        zero_q, zero_d;
  logic [bwa_pkg::DIGIT_W:0]   sum;
  bwa_pkg::digit_t             res;
  logic                        res_carry;

  // one decimal digit add, lowest digit at the ring head
  always_comb begin
    sum = {1'b0, ring_q[0]} + {1'b0, opnd_digit_i} + {{bwa_pkg::DIGIT_W{1'b0}}, carry_q};
    if (!ctrl_i.is_add) begin
      res       = opnd_digit_i;
      res_carry = 1'b0;
    end else if (sum >= {1'b0, bwa_pkg::DEC_BASE}) begin
      res       = bwa_pkg::DIGIT_W'(sum - {1'b0, bwa_pkg::DEC_BASE});
      res_carry = 1'b1;
    end else begin
      res       = sum[bwa_pkg::DIGIT_W-1:0];
      res_carry = 1'b0;
    end
  end

  // carry, tally and zero tracking across the pass
  always_comb begin
    carry_d = carry_q;
    tally_d = tally_q;
    zero_d  = zero_q;
    if (ctrl_i.start) begin
      carry_d = 1'b0;
      tally_d = '0;
      zero_d  = 1'b1;
    end else if (ctrl_i.add_en) begin
      carry_d = res_carry;
      zero_d  = zero_q & (res == '0);
      if (res_carry && (tally_q < bwa_pkg::TALLY_W'(bwa_pkg::TALLY_MAX))) begin
        tally_d = tally_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 1'b0;
      tally_q <= '0;
      zero_q  <= 1'b1;
    end else begin
      carry_q <= carry_d;
      tally_q <= tally_d;
      zero_q  <= zero_d;
    end
  end

  // digit ring rotation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bwa_pkg::NUM_DIGITS; i++) begin
        ring_q[i] <= '0;
      end
    end else if (ctrl_i.add_en) begin
      for (int i = 0; i < bwa_pkg::NUM_DIGITS - 1; i++) begin
        ring_q[i] <= ring_q[i+1];
      end
      ring_q[bwa_pkg::NUM_DIGITS-1] <= res;
    end else if (ctrl_i.read_en) begin
      for (int i = 1; i < bwa_pkg::NUM_DIGITS; i++) begin
        ring_q[i] <= ring_q[i-1];
      end
      ring_q[0] <= ring_q[bwa_pkg::NUM_DIGITS-1];
    end
  end

  assign top_digit_o = ring_q[bwa_pkg::NUM_DIGITS-1];
  assign tally_o     = tally_q;
  assign zero_o      = zero_q;

endmodule

[rtl/core/bwa_d2b.sv]
// ----------------------------------------------------------------------------
// bwa_d2b
// Digit-serial BCD to binary readout: Horner accumulation, top digit first,
// times ten then plus the digit on each step.
// ----------------------------------------------------------------------------
module bwa_d2b (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bwa_pkg::ctrl_t              ctrl_i,
  input  bwa_pkg::digit_t             digit_i,
  output logic [bwa_pkg::OPND_W-1:0]  value_o
);

  logic [bwa_pkg::OPND_W-1:0] acc_q, acc_d;

  // acc * 10 + digit, shift-and-add form
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.start) begin
      acc_d = '0;
    end else if (ctrl_i.read_en && ctrl_i.read_take) begin
      acc_d = (acc_q << 3) + (acc_q << 1)
            + {{(bwa_pkg::OPND_W-bwa_pkg::DIGIT_W){1'b0}}, digit_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign value_o = acc_q;

endmodule

[rtl/core/bcd_wheel_accumulator.sv]
// ----------------------------------------------------------------------------
// bcd_wheel_accumulator
// 24-digit BCD accumulator that loads or adds 64-bit binary words.
// ----------------------------------------------------------------------------
// Each accepted word runs in three serial passes: a bit-serial binary to BCD
// conversion, a pass of the digit ring through a one-digit decimal adder
// (load or add, carry out of the top digit is dropped but still counted),
// and a pass that rotates the ring back while rebuilding the low 19 digits
// as binary. The result then waits until the output register is free. The
// single conversion shift register and digit adder serve one word at a time,
// so no new input word is taken before the last result is in the output
// register. in_stall_o is high from acceptance until the result is in the
// output register, which then holds it independently of the input side.
// ----------------------------------------------------------------------------
module bcd_wheel_accumulator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [bwa_pkg::OPND_W-1:0]        operand_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bwa_pkg::OPND_W-1:0]        low_value_o,
  output logic [bwa_pkg::TALLY_W-1:0]       carry_positions_o,
  output logic                              is_zero_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;

  localparam logic [bwa_pkg::CNT_W-1:0] CONV_LAST =
    bwa_pkg::CNT_W'(bwa_pkg::OPND_W - 1);
  localparam logic [bwa_pkg::CNT_W-1:0] RING_LAST =
    bwa_pkg::CNT_W'(bwa_pkg::NUM_DIGITS - 1);
  localparam logic [bwa_pkg::CNT_W-1:0] TAKE_FIRST =
    bwa_pkg::CNT_W'(bwa_pkg::NUM_DIGITS - bwa_pkg::LOW_DIGITS);

  logic [2:0]                   state_q, state_d;
  logic [bwa_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                         req_q, req_d;
  logic                         in_acc;
  logic                         out_free;
  logic                         out_load;
  logic                         out_valid_q, out_valid_d;
  logic [bwa_pkg::OPND_W-1:0]   low_q;
  logic [bwa_pkg::TALLY_W-1:0]  tally_q;
  logic                         zero_q;
  bwa_pkg::ctrl_t               ctrl;
  bwa_pkg::digit_t              opnd_digit;
  bwa_pkg::digit_t              top_digit;
  logic [bwa_pkg::TALLY_W-1:0]  ring_tally;
  logic                         ring_zero;
  logic [bwa_pkg::OPND_W-1:0]   low_bin;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_WAIT) && out_free;

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    req_d   = req_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CONV;
          cnt_d   = '0;
          req_d   = req_type_i;
        end
      end
      ST_CONV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CONV_LAST) begin
          state_d = ST_ADD;
          cnt_d   = '0;
        end
      end
      ST_ADD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RING_LAST) begin
          state_d = ST_READ;
          cnt_d   = '0;
        end
      end
      ST_READ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RING_LAST) begin
          state_d = ST_WAIT;
          cnt_d   = '0;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      req_q   <= bwa_pkg::REQ_LOAD;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      req_q   <= req_d;
    end
  end

  // strobes to the datapath
  always_comb begin
    ctrl.start     = in_acc;
    ctrl.conv_en   = (state_q == ST_CONV);
    ctrl.add_en    = (state_q == ST_ADD);
    ctrl.read_en   = (state_q == ST_READ);
    ctrl.read_take = (cnt_q >= TAKE_FIRST);
    ctrl.is_add    = (req_q == bwa_pkg::REQ_ADD);
  end

  bwa_b2d u_b2d (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .operand_i (operand_value_i),
    .digit_o   (opnd_digit)
  );

  bwa_ring u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .opnd_digit_i (opnd_digit),
    .top_digit_o  (top_digit),
    .tally_o      (ring_tally),
    .zero_o       (ring_zero)
  );

  bwa_d2b u_d2b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .digit_i (top_digit),
    .value_o (low_bin)
  );

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      low_q   <= low_bin;
      tally_q <= ring_tally;
      zero_q  <= ring_zero;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign low_value_o       = low_q;
  assign carry_positions_o = tally_q;
  assign is_zero_o         = zero_q;

endmodule

[rtl/core/bwa_checker.sv]
// ----------------------------------------------------------------------------
// bwa_checker
// Port-level checks of the decimal wheel accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module bwa_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [bwa_pkg::OPND_W-1:0]        low_value_o,
  input  logic [bwa_pkg::TALLY_W-1:0]       carry_positions_o,
  input  logic                              is_zero_o
);

  // a taken word keeps the input side busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(low_value_o) && $stable(carry_positions_o)
       && $stable(is_zero_o)))
    else $error("stalled result word changed");

  // carry count never exceeds the digit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (carry_positions_o <= bwa_pkg::TALLY_W'(bwa_pkg::NUM_DIGITS)))
    else $error("carry count above digit count");

  // an all-zero accumulator reads as zero in its low digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_zero_o) |-> (low_value_o == '0))
    else $error("zero flag set with nonzero low value");

endmodule

bind bcd_wheel_accumulator bwa_checker u_bwa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .low_value_o       (low_value_o),
  .carry_positions_o (carry_positions_o),
  .is_zero_o         (is_zero_o)
);

[tb/sv/tb_bcd_wheel_accumulator.sv]
// ----------------------------------------------------------------------------
// tb_bcd_wheel_accumulator
// Self-checking bench for the 24-digit decimal wheel accumulator.
// ----------------------------------------------------------------------------
// Words of load and add requests go in through a valid/stall channel. A
// digit-level predictor in the bench keeps its own copy of the decimal
// accumulator and queues the expected low value, carry count and zero flag
// for every accepted word. Each result word is checked in order against that
// queue. The traffic covers operand extremes, long carry ripples, a zero
// low part under a nonzero upper part, random load/add runs under several
// idle and stall mixes, and one long output hold-off that backs up the block.
// ----------------------------------------------------------------------------
module tb_bcd_wheel_accumulator;

  // run limit; this covers the slowest legal run many times
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 150;
  localparam int RADIX        = 10;
  localparam logic [bwa_pkg::OPND_W-1:0] NINES_19  = 64'd9999999999999999999;
  localparam logic [bwa_pkg::OPND_W-1:0] TEN_POW19 = 64'd10000000000000000000;
  localparam logic [bwa_pkg::OPND_W-1:0] OPND_MAX  = '1;

  typedef struct packed {
    logic [bwa_pkg::OPND_W-1:0]  low;
    logic [bwa_pkg::TALLY_W-1:0] carries;
    logic                        zero;
  } acc_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        req_type_i;
  logic [bwa_pkg::OPND_W-1:0]  operand_value_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [bwa_pkg::OPND_W-1:0]  low_value_o;
  logic [bwa_pkg::TALLY_W-1:0] carry_positions_o;
  logic                        is_zero_o;

  // predictor state and expectations
  bwa_pkg::digit_t acc_digits [bwa_pkg::NUM_DIGITS];
  acc_result_t     pending_results [$];
  acc_result_t     head_result;

  // traffic shaping
  int send_idle_pct;
  int out_stall_pct;
  int hold_off_left;
  int burst_left;

  // bookkeeping
  int cycle_count;
  int n_errors;
  int n_checked;
  int n_loads;
  int n_adds;
  int n_zero_results;
  int peak_carries;
  int top_digit_seen;

  bcd_wheel_accumulator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .operand_value_i   (operand_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .low_value_o       (low_value_o),
    .carry_positions_o (carry_positions_o),
    .is_zero_o         (is_zero_o)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output stall: long hold-off first, then bursts, then per-cycle random
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i = 1'b1;
      hold_off_left--;
    end else if (burst_left > 0) begin
      out_stall_i = 1'b1;
      burst_left--;
    end else if (out_stall_pct > 0 && $urandom_range(0, 199) == 0) begin
      burst_left  = $urandom_range(20, 150);
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation: low_value %0d", low_value_o);
        n_errors++;
      end else begin
        head_result = pending_results.pop_front();
        n_checked++;
        if (low_value_o !== head_result.low) begin
          $error("low_value: expected %0d, got %0d", head_result.low, low_value_o);
          n_errors++;
        end
        if (carry_positions_o !== head_result.carries) begin
          $error("carry_positions: expected %0d, got %0d",
                 head_result.carries, carry_positions_o);
          n_errors++;
        end
        if (is_zero_o !== head_result.zero) begin
          $error("is_zero: expected %0d, got %0d", head_result.zero, is_zero_o);
          n_errors++;
        end
      end
    end
  end

  // digit-level model of one load or add, queues the expected result word
  task automatic predict_step(input logic req, input logic [bwa_pkg::OPND_W-1:0] value);
    logic [bwa_pkg::OPND_W-1:0] rest;
    logic [bwa_pkg::OPND_W-1:0] weight;
    bwa_pkg::digit_t            opnd;
    int                         carry;
    int                         sum;
    int                         count;
    acc_result_t                want;
    rest  = value;
    carry = 0;
    count = 0;
    for (int i = 0; i < bwa_pkg::NUM_DIGITS; i++) begin
      opnd = bwa_pkg::digit_t'(rest % RADIX);
      rest = rest / RADIX;
      if (req == bwa_pkg::REQ_LOAD) begin
        acc_digits[i] = opnd;
      end else begin
        sum           = int'(acc_digits[i]) + int'(opnd) + carry;
        acc_digits[i] = bwa_pkg::digit_t'(sum % RADIX);
        carry         = sum / RADIX;
        // top digit carry is dropped but still counted
        if (carry != 0 && count < bwa_pkg::TALLY_MAX) count++;
      end
    end
    // rebuild low digits as binary, flag on the whole accumulator
    want.low     = '0;
    want.carries = bwa_pkg::TALLY_W'(count);
    want.zero    = 1'b1;
    weight       = 1;
    for (int i = 0; i < bwa_pkg::NUM_DIGITS; i++) begin
      if (i < bwa_pkg::LOW_DIGITS) begin
        want.low = want.low + bwa_pkg::OPND_W'(acc_digits[i]) * weight;
        weight   = weight * RADIX;
      end
      if (acc_digits[i] != 0) begin
        want.zero = 1'b0;
        if (i > top_digit_seen) top_digit_seen = i;
      end
    end
    if (req == bwa_pkg::REQ_LOAD) n_loads++;
    else n_adds++;
    if (want.zero) n_zero_results++;
    if (count > peak_carries) peak_carries = count;
    pending_results.push_back(want);
  endtask

  // offer one word after an optional idle gap, return once it is taken
  task automatic send_word(input logic req, input logic [bwa_pkg::OPND_W-1:0] value);
    int gap;
    gap = 0;
    if (send_idle_pct > 0 && $urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 200);
    end else begin
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
    end
    @(negedge clk_i);
    while (gap > 0) begin
      in_valid_i      = 1'b0;
      req_type_i      = 1'($urandom);
      operand_value_i = {$urandom, $urandom};
      gap--;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    req_type_i      = req;
    operand_value_i = value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_step(req, value);
  endtask

  // withdraw the taken word, then wait for every expected result
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // operand extremes and bit patterns
  task automatic test_operand_extremes();
    send_word(bwa_pkg::REQ_LOAD, '0);
    send_word(bwa_pkg::REQ_ADD,  '0);
    send_word(bwa_pkg::REQ_LOAD, OPND_MAX);
    send_word(bwa_pkg::REQ_ADD,  OPND_MAX);
    send_word(bwa_pkg::REQ_ADD,  '0);
    send_word(bwa_pkg::REQ_LOAD, 64'h5555_5555_5555_5555);
    send_word(bwa_pkg::REQ_ADD,  64'hAAAA_AAAA_AAAA_AAAA);
    send_word(bwa_pkg::REQ_ADD,  64'd1);
    send_word(bwa_pkg::REQ_LOAD, '0);
    send_word(bwa_pkg::REQ_ADD,  64'd1);
  endtask

  // carry chains, zero low part under nonzero upper digits
  task automatic test_carry_ripple();
    send_word(bwa_pkg::REQ_LOAD, NINES_19);
    send_word(bwa_pkg::REQ_ADD,  64'd1);
    send_word(bwa_pkg::REQ_LOAD, NINES_19);
    send_word(bwa_pkg::REQ_ADD,  NINES_19);
    send_word(bwa_pkg::REQ_LOAD, 64'd1);
    send_word(bwa_pkg::REQ_ADD,  64'd9);
    send_word(bwa_pkg::REQ_LOAD, TEN_POW19);
    send_word(bwa_pkg::REQ_ADD,  OPND_MAX);
    send_word(bwa_pkg::REQ_ADD,  OPND_MAX);
    send_word(bwa_pkg::REQ_LOAD, '0);
    // overflow past the top digit needs tens of thousands of full-scale adds,
    // far beyond this run length
  endtask

  // random load/add runs under a given idle and stall mix
  task automatic test_random_traffic(input int words, input int idle_pct, input int stall_pct);
    logic                       req;
    logic [bwa_pkg::OPND_W-1:0] value;
    logic [bwa_pkg::OPND_W-1:0] pow;
    int                         k;
    send_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    for (int n = 0; n < words; n++) begin
      req = ($urandom_range(0, 99) < 18) ? bwa_pkg::REQ_LOAD : bwa_pkg::REQ_ADD;
      case ($urandom_range(0, 5))
        0: value = '0;
        1: value = bwa_pkg::OPND_W'($urandom_range(0, 999));
        2: begin
          k   = $urandom_range(1, 19);
          pow = 1;
          repeat (k) pow = pow * RADIX;
          value = ($urandom_range(0, 1) == 0) ? pow - 1 : pow;
        end
        3: value = OPND_MAX - bwa_pkg::OPND_W'($urandom_range(0, 1000));
        default: value = {$urandom, $urandom};
      endcase
      send_word(req, value);
    end
    wait_results_drained();
  endtask

  // hold the output long enough that the block backs up onto its input
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    out_stall_pct = 0;
    @(posedge clk_i);
    hold_off_left = 700;
    send_word(bwa_pkg::REQ_LOAD, {$urandom, $urandom});
    repeat (5) send_word(bwa_pkg::REQ_ADD, {$urandom, $urandom});
    wait_results_drained();
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    req_type_i      = bwa_pkg::REQ_LOAD;
    operand_value_i = '0;
    out_stall_i     = 1'b0;
    send_idle_pct   = 0;
    out_stall_pct   = 0;
    hold_off_left   = 0;
    burst_left      = 0;
    cycle_count     = 0;
    n_errors        = 0;
    n_checked       = 0;
    n_loads         = 0;
    n_adds          = 0;
    n_zero_results  = 0;
    peak_carries    = 0;
    top_digit_seen  = 0;
    for (int i = 0; i < bwa_pkg::NUM_DIGITS; i++) acc_digits[i] = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_operand_extremes();
    test_carry_ripple();
    wait_results_drained();
    test_random_traffic(110, 0, 0);
    test_random_traffic(110, 68, 0);
    test_random_traffic(110, 0, 68);
    test_random_traffic(110, 7, 7);
    test_output_backpressure();

    // quiet inputs, drain, then watch for stray result words
    send_idle_pct = 0;
    out_stall_pct = 0;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words (%0d loads, %0d adds), %0d result words checked",
             n_loads + n_adds, n_loads, n_adds, n_checked);
    $display("peak carry count %0d, highest nonzero digit %0d, %0d zero results",
             peak_carries, top_digit_seen, n_zero_results);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
